@@ sv/kwm_pkg.sv @@
// Package for the k-way merge block: sizes, function codes and the controller/datapath command struct.
// No dependencies.
package kwm_pkg;

    localparam int BufferDepth = 1024;
    localparam int MaxChunks   = 16;
    localparam int IdxW        = $clog2(BufferDepth);
    localparam int PtrW        = IdxW + 1;
    localparam int ChunkW      = $clog2(MaxChunks);
    localparam int KeyW        = 64;
    localparam int CountW      = 5;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TAKE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              do_load;     // Perform a load with the captured item.
        logic              head_clear;  // Reset the cached head search.
        logic              head_step;   // Consider the head of one chunk.
        logic [ChunkW-1:0] head_chunk;  // Chunk whose head is read now; read data is of the chunk before.
        logic              head_read;   // Issue a key read for head_chunk.
        logic              emit;        // Build the result and advance the cursor.
    } kwm_cmd_t;

endpackage

@@ sv/kwm_ram.sv @@
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
module kwm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/kwm_datapath.sv @@
// Datapath of the k-way merge: key RAM, chunk tables, load checks and head search.
// Depends on kwm_pkg and kwm_ram.
module kwm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kwm_pkg::CountW-1:0]     cfg_wdata,
    input  logic                           start_set,
    input  logic [kwm_pkg::KeyW-1:0]       key_bits,
    input  logic [kwm_pkg::ChunkW-1:0]     chunk_tag,
    input  kwm_pkg::kwm_cmd_t              cmd,
    output logic [kwm_pkg::IdxW-1:0]       res_index,
    output logic [kwm_pkg::KeyW-1:0]       res_key,
    output logic [kwm_pkg::ChunkW-1:0]     res_chunk,
    output logic                           res_final,
    output logic                           res_empty,
    output logic                           res_error
);

    logic [kwm_pkg::CountW-1:0]  count_reg;
    logic [kwm_pkg::PtrW-1:0]    end_reg    [kwm_pkg::MaxChunks];
    logic [kwm_pkg::PtrW-1:0]    cursor_reg [kwm_pkg::MaxChunks];
    logic [kwm_pkg::PtrW-1:0]    wptr_reg;
    logic [kwm_pkg::ChunkW-1:0]  last_tag_reg;
    logic [kwm_pkg::PtrW-1:0]    remain_reg;
    logic                        error_reg;
    logic                        found_reg;
    logic [kwm_pkg::ChunkW-1:0]  best_reg;
    logic [kwm_pkg::KeyW-1:0]    best_key_reg;
    logic                        hv_reg;  // Head of the chunk being read is live.

    logic [kwm_pkg::PtrW-1:0]    wptr_eff;
    logic                        tag_ok;
    logic                        load_ok;
    logic [kwm_pkg::CountW-1:0]  limit;
    logic [kwm_pkg::KeyW-1:0]    rd_key;
    logic [kwm_pkg::IdxW-1:0]    rd_addr;
    logic                        head_live;

    // Load acceptance checks against the possibly cleared set, and the head read address and liveness.
    always_comb
    begin
        limit    = (count_reg > kwm_pkg::CountW'(kwm_pkg::MaxChunks))
                   ? kwm_pkg::CountW'(kwm_pkg::MaxChunks) : count_reg;
        wptr_eff = start_set ? '0 : wptr_reg;
        tag_ok   = {1'b0, chunk_tag} < limit;
        load_ok  = tag_ok
                   && !(wptr_eff != '0 && chunk_tag < (start_set ? '0 : last_tag_reg))
                   && (wptr_eff < kwm_pkg::PtrW'(kwm_pkg::BufferDepth));
        head_live = (cursor_reg[cmd.head_chunk] < end_reg[cmd.head_chunk]);
        rd_addr   = cursor_reg[cmd.head_chunk][kwm_pkg::IdxW-1:0];
    end

    kwm_ram #(
        .Width (kwm_pkg::KeyW),
        .Depth (kwm_pkg::BufferDepth)
    ) u_keys (
        .clk   (clk),
        .we    (cmd.do_load && load_ok),
        .waddr (wptr_eff[kwm_pkg::IdxW-1:0]),
        .wdata (key_bits),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    // Configuration, chunk tables, head search and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= kwm_pkg::CountW'(16);
            for (int i = 0; i < kwm_pkg::MaxChunks; i++)
            begin
                end_reg[i]    <= '0;
                cursor_reg[i] <= '0;
            end
            wptr_reg     <= '0;
            last_tag_reg <= '0;
            remain_reg   <= '0;
            error_reg    <= 1'b0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_key_reg <= '0;
            hv_reg       <= 1'b0;
            res_index    <= '0;
            res_key      <= '0;
            res_chunk    <= '0;
            res_final    <= 1'b0;
            res_empty    <= 1'b0;
            res_error    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.do_load)
            begin
                if (start_set)
                begin
                    for (int i = 0; i < kwm_pkg::MaxChunks; i++)
                    begin
                        end_reg[i]    <= '0;
                        cursor_reg[i] <= '0;
                    end
                end
                if (load_ok)
                begin
                    if (wptr_eff == '0 || chunk_tag != last_tag_reg)
                    begin
                        cursor_reg[chunk_tag] <= wptr_eff;
                    end
                    end_reg[chunk_tag] <= wptr_eff + 1'b1;
                    last_tag_reg       <= chunk_tag;
                    wptr_reg           <= wptr_eff + 1'b1;
                    remain_reg         <= (start_set ? '0 : remain_reg) + 1'b1;
                    error_reg          <= 1'b0 | (!start_set && error_reg);
                end
                else
                begin
                    error_reg <= 1'b1;
                    if (start_set)
                    begin
                        wptr_reg     <= '0;
                        last_tag_reg <= '0;
                        remain_reg   <= '0;
                    end
                end
            end
            if (cmd.head_clear)
            begin
                found_reg <= 1'b0;
            end
            if (cmd.head_read)
            begin
                hv_reg <= head_live;
            end
            // Compare the head whose key arrived this cycle.
            if (cmd.head_step && hv_reg && (!found_reg || rd_key < best_key_reg))
            begin
                found_reg    <= 1'b1;
                best_reg     <= cmd.head_chunk - 1'b1;
                best_key_reg <= rd_key;
            end
            if (cmd.emit)
            begin
                res_error <= error_reg;
                res_empty <= !found_reg;
                if (found_reg)
                begin
                    res_index <= cursor_reg[best_reg][kwm_pkg::IdxW-1:0];
                    res_key   <= best_key_reg;
                    res_chunk <= best_reg;
                    res_final <= (remain_reg == kwm_pkg::PtrW'(1));
                    cursor_reg[best_reg] <= cursor_reg[best_reg] + 1'b1;
                    if (remain_reg != '0)
                    begin
                        remain_reg <= remain_reg - 1'b1;
                    end
                end
                else
                begin
                    res_index <= '0;
                    res_key   <= '0;
                    res_chunk <= '0;
                    res_final <= 1'b0;
                end
            end
        end
    end

    // A cursor never passes its chunk end (asserted for chunk 0); wptr and remain stay bounded.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg[0] <= end_reg[0])
        else $error("cursor of chunk 0 passed its end");
    a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg <= kwm_pkg::PtrW'(kwm_pkg::BufferDepth))
        else $error("write pointer beyond buffer");
    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= wptr_reg)
        else $error("remaining count exceeds stored items");

endmodule

@@ sv/kwm_ctrl.sv @@
// Controller of the k-way merge: handshakes and sequencing of the head search.
// Depends on kwm_pkg.
module kwm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_func,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kwm_pkg::kwm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [kwm_pkg::ChunkW:0]    step_reg;   // Counts read issues, one extra for the last compare.
    logic                        out_valid_reg;
    logic                        accept;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // Command decode from state and input acceptance.
    always_comb
    begin
        cmd            = '0;
        cmd.do_load    = accept && (in_func == kwm_pkg::FUNC_LOAD);
        cmd.head_clear = accept && (in_func == kwm_pkg::FUNC_TAKE);
        cmd.head_chunk = step_reg[kwm_pkg::ChunkW-1:0];
        cmd.head_read  = (state_reg == ST_SCAN) && !step_reg[kwm_pkg::ChunkW];
        cmd.head_step  = (state_reg == ST_SCAN) && (step_reg != '0);
        cmd.emit       = (state_reg == ST_EMIT);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_func == kwm_pkg::FUNC_TAKE)
                    begin
                        state_reg <= ST_SCAN;
                        step_reg  <= '0;
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg[kwm_pkg::ChunkW])
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted during a take");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> out_valid_reg)
        else $error("result not presented after emit");
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SCAN) |-> (step_reg == '0))
        else $error("scan did not start at chunk 0");

endmodule

@@ sv/kway_merge_sorted_chunks_core.sv @@
// Top level of the k-way merge of presorted chunks.
// Depends on kwm_pkg, kwm_ctrl and kwm_datapath.
//
//   Channel   Direction  Content
//   s_axis    in         tdata = key_bits, chunk_tag; tuser = func, start_set
//   m_axis    out        tdata = source_index, out_key, out_chunk; tlast = final_item;
//                        tuser = nothing_left, load_error
//   cfg       in         chunk_count written when cfg_we is high
//
// An accepted load that passes its checks is written into the key RAM and tables. A take reads
// each chunk head in turn through the single key RAM read port, then registers the result.
// Reset clears all chunk tables; the key RAM holds no reset value.
// The input stalls during a take and while a result waits to be taken.
module kway_merge_sorted_chunks_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key_bits[63:0], chunk_tag[67:64], zero fill
    input  logic [1:0]  s_axis_tuser,   // func[0], start_set[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // source_index[9:0], out_key[73:10], out_chunk[77:74]
    output logic        m_axis_tlast,   // final_item
    output logic [1:0]  m_axis_tuser    // nothing_left[0], load_error[1]
);

    kwm_pkg::kwm_cmd_t           cmd;
    logic [kwm_pkg::IdxW-1:0]    res_index;
    logic [kwm_pkg::KeyW-1:0]    res_key;
    logic [kwm_pkg::ChunkW-1:0]  res_chunk;
    logic                        res_final;
    logic                        res_empty;
    logic                        res_error;

    kwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    kwm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start_set (s_axis_tuser[1]),
        .key_bits  (s_axis_tdata[63:0]),
        .chunk_tag (s_axis_tdata[67:64]),
        .cmd       (cmd),
        .res_index (res_index),
        .res_key   (res_key),
        .res_chunk (res_chunk),
        .res_final (res_final),
        .res_empty (res_empty),
        .res_error (res_error)
    );

    // Result packing.
    assign m_axis_tdata = {2'b00, res_chunk, res_key, res_index};
    assign m_axis_tlast = res_final;
    assign m_axis_tuser = {res_error, res_empty};

endmodule

@@ verif/kway_merge_sorted_chunks_core_tb.sv @@
// Testbench for the k-way merge core: loads sorted chunks, takes merged items and checks
// every result against a predictor of the merge. Depends on kwm_pkg and the core.
`timescale 1ns / 1ps

module kway_merge_sorted_chunks_core_tb;

    typedef struct packed {
        logic                       func;
        logic                       start_set;
        logic [kwm_pkg::KeyW-1:0]   key_bits;
        logic [kwm_pkg::ChunkW-1:0] chunk_tag;
    } merge_req_t;

    typedef struct packed {
        logic [kwm_pkg::IdxW-1:0]   source_index;
        logic [kwm_pkg::KeyW-1:0]   out_key;
        logic [kwm_pkg::ChunkW-1:0] out_chunk;
        logic                       final_item;
        logic                       nothing_left;
        logic                       load_error;
    } merge_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // Predictor state.
    logic [kwm_pkg::KeyW-1:0] key_mem [kwm_pkg::BufferDepth];
    int unsigned     chunk_lo  [kwm_pkg::MaxChunks];
    int unsigned     chunk_hi  [kwm_pkg::MaxChunks];
    int unsigned     chunk_rd  [kwm_pkg::MaxChunks];
    int unsigned     wr_ptr;
    int unsigned     prev_tag;
    int unsigned     items_left;
    bit              drop_seen;
    int unsigned     active_chunks;

    merge_req_t  pending_reqs[$];
    merge_out_t  expected_outs[$];
    int          mismatch_count;
    int          take_count;
    int          load_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    kway_merge_sorted_chunks_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Append one item to the pending queue.
    task automatic queue_req(input merge_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Clear the predictor tables for a new set.
    task automatic clear_tables();
        for (int c = 0; c < kwm_pkg::MaxChunks; c++)
        begin
            chunk_lo[c] = 0;
            chunk_hi[c] = 0;
            chunk_rd[c] = 0;
        end
        wr_ptr     = 0;
        prev_tag   = 0;
        items_left = 0;
        drop_seen  = 1'b0;
    endtask

    // Apply one accepted item to the predictor; a take queues its result.
    task automatic predict_merge(input merge_req_t req);
        int unsigned lim;
        int unsigned tag;
        int          best;
        logic [kwm_pkg::KeyW-1:0] best_key;
        merge_out_t  res;
        begin
            tag = req.chunk_tag;
            if (req.func == kwm_pkg::FUNC_LOAD)
            begin
                if (req.start_set)
                    clear_tables();
                lim = (active_chunks > kwm_pkg::MaxChunks) ? kwm_pkg::MaxChunks : active_chunks;
                if (tag >= lim || (wr_ptr != 0 && tag < prev_tag)
                    || wr_ptr >= kwm_pkg::BufferDepth)
                begin
                    drop_seen = 1'b1;
                end
                else
                begin
                    key_mem[wr_ptr] = req.key_bits;
                    if (wr_ptr == 0 || tag != prev_tag)
                    begin
                        chunk_lo[tag] = wr_ptr;
                        chunk_rd[tag] = wr_ptr;
                    end
                    chunk_hi[tag] = wr_ptr + 1;
                    prev_tag = tag;
                    wr_ptr++;
                    items_left++;
                end
            end
            else
            begin
                best = -1;
                best_key = '0;
                for (int c = 0; c < kwm_pkg::MaxChunks; c++)
                begin
                    if (chunk_rd[c] < chunk_hi[c] && chunk_rd[c] < kwm_pkg::BufferDepth)
                    begin
                        if (best < 0 || key_mem[chunk_rd[c]] < best_key)
                        begin
                            best = c;
                            best_key = key_mem[chunk_rd[c]];
                        end
                    end
                end
                res = '0;
                res.load_error = drop_seen;
                if (best < 0)
                begin
                    res.nothing_left = 1'b1;
                end
                else
                begin
                    res.source_index = chunk_rd[best][kwm_pkg::IdxW-1:0];
                    res.out_key      = best_key;
                    res.out_chunk    = best[kwm_pkg::ChunkW-1:0];
                    res.final_item   = (items_left == 1);
                    chunk_rd[best]++;
                    if (items_left > 0)
                        items_left--;
                end
                expected_outs.insert(expected_outs.size(), res);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Driver: present the head of the pending queue, advancing on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_merge(pending_reqs.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) )
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, pending_reqs[0].chunk_tag, pending_reqs[0].key_bits};
                    s_axis_tuser  <= {pending_reqs[0].start_set, pending_reqs[0].func};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off counter, counted down once per cycle.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        merge_out_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_outs.size() == 0)
                begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 64'h0);
                end
                else
                begin
                    want = expected_outs.pop_front();
                    take_count++;
                    if (m_axis_tdata[9:0] != want.source_index)
                        report_mismatch("source_index", 64'(m_axis_tdata[9:0]),
                                        64'(want.source_index));
                    if (m_axis_tdata[73:10] != want.out_key)
                        report_mismatch("out_key", m_axis_tdata[73:10], want.out_key);
                    if (m_axis_tdata[77:74] != want.out_chunk)
                        report_mismatch("out_chunk", 64'(m_axis_tdata[77:74]),
                                        64'(want.out_chunk));
                    if (m_axis_tlast != want.final_item)
                        report_mismatch("final_item", 64'(m_axis_tlast), 64'(want.final_item));
                    if (m_axis_tuser[0] != want.nothing_left)
                        report_mismatch("nothing_left", 64'(m_axis_tuser[0]),
                                        64'(want.nothing_left));
                    if (m_axis_tuser[1] != want.load_error)
                        report_mismatch("load_error", 64'(m_axis_tuser[1]),
                                        64'(want.load_error));
                end
            end
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic merge_req_t make_load(input bit fresh,
                                             input logic [kwm_pkg::KeyW-1:0] key,
                                             input int unsigned tag);
        merge_req_t r;
        r.func      = kwm_pkg::FUNC_LOAD;
        r.start_set = fresh;
        r.key_bits  = key;
        r.chunk_tag = tag[kwm_pkg::ChunkW-1:0];
        return r;
    endfunction

    function automatic merge_req_t make_take();
        merge_req_t r;
        r.func      = kwm_pkg::FUNC_TAKE;
        r.start_set = $urandom_range(1);
        r.key_bits  = {$urandom, $urandom};
        r.chunk_tag = $urandom_range(15);
        return r;
    endfunction

    // Wait until every queued item is accepted and every result is in, then settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_outs.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        active_chunks = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One set: sorted chunks with random content, stray loads and interleaved takes, then takes.
    task automatic queue_set(input int unsigned n_items, input int unsigned n_takes);
        int unsigned tag;
        logic [kwm_pkg::KeyW-1:0] key;
        bit fresh;
        begin
            tag = 0;
            key = 0;
            fresh = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(99) < 25)
                begin
                    tag = tag + $urandom_range(1, 3);
                    key = ($urandom_range(3) == 0) ? {$urandom, $urandom} >> $urandom_range(63)
                                                   : 0;
                end
                if ($urandom_range(99) < 4)
                    queue_req(make_load(1'b0, {$urandom, $urandom}, $urandom_range(15)));
                else
                    queue_req(make_load(fresh, key, tag % 16));
                fresh = 1'b0;
                key = key + ($urandom_range(2) == 0 ? 0 : {$urandom, $urandom} >> 40);
                if ($urandom_range(99) < 10)
                    queue_req(make_take());
            end
            for (int i = 0; i < n_takes; i++)
                queue_req(make_take());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatch_count = 0;
        take_count = 0;
        load_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        active_chunks = 16;
        clear_tables();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty take, extremes of keys and tags, and an order error.
        queue_req(make_take());
        queue_req(make_load(1'b1, 64'h0, 0));
        queue_req(make_load(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        queue_req(make_load(1'b0, 64'h0, 3));
        queue_req(make_load(1'b0, 64'h8000_0000_0000_0000, 3));
        queue_req(make_load(1'b0, 64'h3FF0_0000_0000_0000, 15));
        queue_req(make_load(1'b0, 64'h0, 2));
        queue_req(make_take());
        queue_req(make_take());
        queue_req(make_load(1'b0, 64'h4000_0000_0000_0000, 15));
        for (int i = 0; i < 6; i++)
            queue_req(make_take());
        drain();

        // A small chunk count rejects larger tags; a zero count rejects all.
        write_count(5'd3);
        queue_req(make_load(1'b1, 64'h10, 3));
        queue_req(make_load(1'b0, 64'h5, 2));
        queue_req(make_take());
        queue_req(make_take());
        drain();
        write_count(5'd0);
        queue_req(make_load(1'b1, 64'h1, 0));
        queue_req(make_take());
        drain();
        write_count(5'd31);

        // A longer set under long receiver hold-off.
        hold_cycles = 300;
        for (int i = 0; i < 60; i++)
            queue_req(make_load(i == 0, 64'(i), i / 10));
        for (int i = 0; i < 10; i++)
            queue_req(make_take());
        drain();

        // Random phases across idling profiles and chunk counts.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            write_count(ph == 7 ? 5'd1 : (ph == 3 ? 5'd16 : 5'($urandom_range(1, 31))));
            if (ph == 2)
                hold_cycles = 400;
            for (int s = 0; s < 2; s++)
                queue_set($urandom_range(12, 36), $urandom_range(8, 36));
            drain();
        end

        if (mismatch_count == 0)
            $display("Covered directed extremes, tag errors, hold-off and %0d results.",
                     take_count);
        else
            $display("Checked %0d results, %0d mismatches.", take_count, mismatch_count);
        if (mismatch_count == 0 && expected_outs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/kwm_pkg.sv
sv/kwm_ram.sv
sv/kwm_datapath.sv
sv/kwm_ctrl.sv
sv/kway_merge_sorted_chunks_core.sv
verif/kway_merge_sorted_chunks_core_tb.sv
